FILE: sv/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Shared request, result and queue item types, command codes and phases.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd1;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd2;
  localparam logic [2:0] CMD_WRITE_BITS = 3'd3;
  localparam logic [2:0] CMD_READ_BITS  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [7:0] MSB_MASK      = 8'h80;

  localparam int LC_STOP_POS = 3;
  localparam int LC_NACK_POS = 4;
  localparam int LC_ACK_POS  = 5;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

  typedef struct packed {
    logic [2:0] command;
    logic       with_start;
    logic       with_stop;
    logic       nack_to_send;
    logic [7:0] data_byte;
    logic [3:0] bare_bits;
    logic       scl_in;
    logic       sda_in;
  } in_req_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_res_t;

  typedef struct packed {
    logic       cmd_ok;
    logic       start_req;
    logic [5:0] lc_init;
    logic [7:0] shift_init;
    logic [3:0] bits_init;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RS_SDA,
    PH_RS_SCL,
    PH_RS_SETUP,
    PH_ST_LOW,
    PH_BIT_SETUP,
    PH_BIT_RISE,
    PH_BIT_HOLD,
    PH_SP_LOW,
    PH_SP_RISE,
    PH_SP_SETUP,
    PH_SP_HIGH
  } phase_t;

endpackage

`default_nettype wire

FILE: sv/i2cbm_front.sv
// ----------------------------------------------------------------------------
// I2C bit-level master front end
// Classifies each incoming request into a queue item for the bus engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_front (
  input  var i2cbm_pkg::in_req_t req,
  output var i2cbm_pkg::item_t   item
);
  import i2cbm_pkg::*;

  logic [3:0] cnt_clamped;
  logic       is_byte;
  logic       is_write;

  always_comb begin
    cnt_clamped = (req.bare_bits > BITS_PER_BYTE) ? BITS_PER_BYTE : req.bare_bits;
    is_byte     = (req.command == CMD_WRITE_BYTE) || (req.command == CMD_READ_BYTE);
    is_write    = (req.command == CMD_WRITE_BYTE) || (req.command == CMD_WRITE_BITS);

    item.cmd_ok     = (req.command == CMD_WRITE_BYTE) || (req.command == CMD_READ_BYTE) ||
                      (req.command == CMD_WRITE_BITS) || (req.command == CMD_READ_BITS);
    item.start_req  = (req.command == CMD_WRITE_BYTE) && req.with_start;
    item.lc_init    = {1'b0, req.nack_to_send, req.with_stop, req.command};
    item.shift_init = is_write ? req.data_byte : 8'h00;
    item.bits_init  = is_byte ? BITS_PER_BYTE : cnt_clamped;
    item.scl_in     = req.scl_in;
    item.sda_in     = req.sda_in;
  end

endmodule

`default_nettype wire

FILE: sv/i2cbm_queue.sv
// ----------------------------------------------------------------------------
// I2C bit-level master request queue
// Two-entry queue between the front end and the bus engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_queue (
  input  var logic            clk,
  input  var logic            rst_n,
  input  var logic            push,
  input  var i2cbm_pkg::item_t push_item,
  output var logic            full,
  input  var logic            pop,
  output var logic            not_empty,
  output var i2cbm_pkg::item_t head
);
  import i2cbm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/i2cbm_engine.sv
// ----------------------------------------------------------------------------
// I2C bit-level master bus engine
// Steps the bus sequencer once per queued request and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_engine (
  input  var logic              clk,
  input  var logic              rst_n,
  input  var logic              cfg_we,
  input  var logic [15:0]       cfg_wdata,
  input  var logic              q_not_empty,
  input  var i2cbm_pkg::item_t  q_head,
  output var logic              q_pop,
  output var logic              out_valid,
  input  var logic              out_stall,
  output var i2cbm_pkg::out_res_t out_res
);
  import i2cbm_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [15:0] dcnt_r,    dcnt_nxt;
  logic [3:0]  bits_r,    bits_nxt;
  logic [7:0]  shift_r,   shift_nxt;
  logic        started_r, started_nxt;
  logic [5:0]  lc_r,      lc_nxt;
  logic        scl_r,     scl_nxt;
  logic        sda_r,     sda_nxt;
  logic        nack_r,    nack_nxt;
  logic [15:0] hp_r,      hp_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_res_t    out_res_r,   out_res_nxt;

  logic        step;
  logic        done_nxt;
  logic        do_begin;
  logic        do_finish;
  logic [15:0] hp_eff;
  logic [2:0]  cmd_cur;

  function automatic logic bit_is_input(input logic [5:0] lc);
    logic ack;
    ack = lc[LC_ACK_POS];
    return (lc[2:0] == CMD_READ_BITS) || ((lc[2:0] == CMD_READ_BYTE) && !ack) ||
           ((lc[2:0] == CMD_WRITE_BYTE) && ack);
  endfunction

  assign step      = q_not_empty && (!out_valid_r || !out_stall);
  assign q_pop     = step;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign hp_eff    = (hp_r == 16'd0) ? 16'd1 : hp_r;
  assign hp_nxt    = cfg_we ? cfg_wdata : hp_r;

  always_comb begin
    phase_nxt   = phase_r;
    dcnt_nxt    = dcnt_r;
    bits_nxt    = bits_r;
    shift_nxt   = shift_r;
    started_nxt = started_r;
    lc_nxt      = lc_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    nack_nxt    = nack_r;
    done_nxt    = 1'b0;
    do_begin    = 1'b0;
    do_finish   = 1'b0;
    cmd_cur     = lc_r[2:0];

    if (step) begin
      unique case (phase_r) inside
        PH_IDLE: begin
          if (q_head.cmd_ok) begin
            lc_nxt    = q_head.lc_init;
            shift_nxt = q_head.shift_init;
            bits_nxt  = q_head.bits_init;
            if (q_head.start_req) begin
              dcnt_nxt = hp_eff;
              if (started_r) begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_RS_SDA;
              end else begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_ST_LOW;
              end
            end else begin
              do_begin = 1'b1;
            end
          end
        end
        PH_RS_SCL: begin
          if (q_head.scl_in) begin
            phase_nxt = PH_RS_SETUP;
            dcnt_nxt  = hp_eff;
          end
        end
        PH_SP_RISE: begin
          if (q_head.scl_in) begin
            phase_nxt = PH_SP_SETUP;
            dcnt_nxt  = hp_eff;
          end
        end
        PH_BIT_RISE: begin
          if (q_head.scl_in) begin
            if (lc_r[LC_ACK_POS]) begin
              if (cmd_cur == CMD_WRITE_BYTE) begin
                nack_nxt = q_head.sda_in;
              end
            end else if (bit_is_input(lc_r)) begin
              shift_nxt = {shift_r[6:0], q_head.sda_in};
            end else begin
              shift_nxt = {shift_r[6:0], 1'b0};
            end
            phase_nxt = PH_BIT_HOLD;
            dcnt_nxt  = hp_eff;
          end
        end
        PH_RS_SDA, PH_RS_SETUP, PH_ST_LOW, PH_BIT_SETUP, PH_BIT_HOLD,
        PH_SP_LOW, PH_SP_SETUP, PH_SP_HIGH: begin
          if (dcnt_r > 16'd1) begin
            dcnt_nxt = dcnt_r - 16'd1;
          end else begin
            unique case (phase_r)
              PH_RS_SDA: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_RS_SCL;
              end
              PH_RS_SETUP: begin
                sda_nxt   = 1'b0;
                phase_nxt = PH_ST_LOW;
                dcnt_nxt  = hp_eff;
              end
              PH_ST_LOW: begin
                scl_nxt     = 1'b0;
                started_nxt = 1'b1;
                do_begin    = 1'b1;
              end
              PH_BIT_SETUP: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_BIT_RISE;
              end
              PH_BIT_HOLD: begin
                scl_nxt = 1'b0;
                if (lc_r[LC_ACK_POS]) begin
                  lc_nxt[LC_ACK_POS] = 1'b0;
                  do_finish          = 1'b1;
                end else begin
                  if (bits_r != 4'd0) begin
                    bits_nxt = bits_r - 4'd1;
                  end
                  do_begin = 1'b1;
                end
              end
              PH_SP_LOW: begin
                scl_nxt   = 1'b1;
                phase_nxt = PH_SP_RISE;
              end
              PH_SP_SETUP: begin
                sda_nxt   = 1'b1;
                phase_nxt = PH_SP_HIGH;
                dcnt_nxt  = hp_eff;
              end
              PH_SP_HIGH: begin
                started_nxt = 1'b0;
                phase_nxt   = PH_IDLE;
                done_nxt    = 1'b1;
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // begin the next bit, or the acknowledge bit after a full byte, or finish
      if (do_begin) begin
        if (bits_nxt == 4'd0) begin
          if (((lc_nxt[2:0] == CMD_WRITE_BYTE) || (lc_nxt[2:0] == CMD_READ_BYTE)) &&
              !lc_nxt[LC_ACK_POS]) begin
            lc_nxt[LC_ACK_POS] = 1'b1;
          end else begin
            do_finish = 1'b1;
          end
        end
        if (!do_finish) begin
          if (bit_is_input(lc_nxt)) begin
            sda_nxt = 1'b1;
          end else if (lc_nxt[LC_ACK_POS]) begin
            sda_nxt = lc_nxt[LC_NACK_POS];
          end else begin
            sda_nxt = |(shift_nxt & MSB_MASK);
          end
          phase_nxt = PH_BIT_SETUP;
          dcnt_nxt  = hp_eff;
        end
      end

      if (do_finish) begin
        if (((lc_nxt[2:0] == CMD_WRITE_BYTE) || (lc_nxt[2:0] == CMD_READ_BYTE)) &&
            lc_nxt[LC_STOP_POS]) begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_SP_LOW;
          dcnt_nxt  = hp_eff;
        end else begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (step) begin
      out_valid_nxt           = 1'b1;
      out_res_nxt.scl_release = scl_nxt;
      out_res_nxt.sda_release = sda_nxt;
      out_res_nxt.busy_res    = (phase_nxt != PH_IDLE);
      out_res_nxt.done_res    = done_nxt;
      out_res_nxt.read_data   = shift_nxt;
      out_res_nxt.nack_seen   = nack_nxt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      dcnt_r      <= 16'd0;
      bits_r      <= 4'd0;
      shift_r     <= 8'h00;
      started_r   <= 1'b0;
      lc_r        <= 6'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      nack_r      <= 1'b0;
      hp_r        <= HALF_PERIOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      dcnt_r      <= dcnt_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      started_r   <= started_nxt;
      lc_r        <= lc_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      nack_r      <= nack_nxt;
      hp_r        <= hp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && done_nxt) |=> (phase_r == PH_IDLE))
    else $error("done pulse without return to idle");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(phase_r) && $stable(shift_r)))
    else $error("engine advanced while result stalled");

  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_BIT_SETUP) || (phase_r == PH_BIT_HOLD) || (phase_r == PH_ST_LOW) ||
     (phase_r == PH_SP_HIGH)) |-> (dcnt_r != 16'd0))
    else $error("delay phase with zero count");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= BITS_PER_BYTE)
    else $error("bit counter out of range");

endmodule

`default_nettype wire

FILE: sv/i2c_bit_level_master_unit.sv
// ----------------------------------------------------------------------------
// I2C bit-level master unit
// Open-drain I2C master stepped once per request tick, front end and engine
// joined by a two-entry queue.
// ----------------------------------------------------------------------------
// Path: an accepted request is written into the queue; the engine steps it from
//   the queue head and loads the result register, from which it is offered.
// Throughput: one request per cycle while the result is not stalled; a
//   stalled result holds the engine and the two-entry queue then stalls input.
// Reset: synchronous, active low; bus lines released, queue emptied,
//   half period set to 500 ticks.
`default_nettype none

module i2c_bit_level_master_unit (
  input  var logic                  clk,
  input  var logic                  rst_n,
  input  var logic                  cfg_we,
  input  var logic [15:0]           cfg_wdata,
  input  var logic                  in_valid,
  output var logic                  in_stall,
  input  var i2cbm_pkg::in_req_t    in_req,
  output var logic                  out_valid,
  input  var logic                  out_stall,
  output var i2cbm_pkg::out_res_t   out_res
);
  import i2cbm_pkg::*;

  item_t front_item;
  item_t q_head;
  logic  q_full;
  logic  q_not_empty;
  logic  q_pop;
  logic  push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  i2cbm_front u_front (
    .req  (in_req),
    .item (front_item)
  );

  i2cbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  i2cbm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

endmodule

`default_nettype wire
